/* design/ncc_pkg.sv */
// Shared constants, types and codes of the nearest-centroid classifier.
package ncc_pkg;

  localparam int FEATURE_W         = 16;
  localparam int NUM_FEATURES      = 5;
  localparam int INDEX_W           = 6;
  localparam int LABEL_W           = 4;
  localparam int COUNT_W           = 7;
  localparam int SQ_W              = 2 * FEATURE_W;
  localparam int DIST_W            = SQ_W + $clog2(NUM_FEATURES);
  localparam int MAX_CENTROIDS_DEF = 64;

  typedef enum logic {
    CMD_LOAD     = 1'b0,
    CMD_CLASSIFY = 1'b1
  } ncc_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } ncc_state_t;

  typedef struct packed {
    logic               valid;
    logic               last;
    logic [INDEX_W-1:0] index;
    logic [LABEL_W-1:0] label;
  } ncc_tag_t;

  typedef struct packed {
    logic               found;
    logic [LABEL_W-1:0] label;
    logic [INDEX_W-1:0] index;
    logic [DIST_W-1:0]  sq_distance;
  } ncc_best_t;

endpackage

/* design/ncc_chan_if.sv */
// Request and result channel interfaces of the nearest-centroid classifier.
interface ncc_in_if;
  logic                         valid;
  logic                         ready;
  logic                         cmd;
  logic [ncc_pkg::INDEX_W-1:0]   entry_index;
  logic [ncc_pkg::LABEL_W-1:0]   entry_label;
  logic [ncc_pkg::FEATURE_W-1:0] feature_0;
  logic [ncc_pkg::FEATURE_W-1:0] feature_1;
  logic [ncc_pkg::FEATURE_W-1:0] feature_2;
  logic [ncc_pkg::FEATURE_W-1:0] feature_3;
  logic [ncc_pkg::FEATURE_W-1:0] feature_4;

  modport source (
    output valid, cmd, entry_index, entry_label,
    output feature_0, feature_1, feature_2, feature_3, feature_4,
    input  ready
  );
  modport sink (
    input  valid, cmd, entry_index, entry_label,
    input  feature_0, feature_1, feature_2, feature_3, feature_4,
    output ready
  );
endinterface

interface ncc_out_if;
  logic                        valid;
  logic                        ready;
  logic                        found;
  logic [ncc_pkg::LABEL_W-1:0] best_label;
  logic [ncc_pkg::INDEX_W-1:0] best_index;
  logic [ncc_pkg::DIST_W-1:0]  best_sq_distance;

  modport source (
    output valid, found, best_label, best_index, best_sq_distance,
    input  ready
  );
  modport sink (
    input  valid, found, best_label, best_index, best_sq_distance,
    output ready
  );
endinterface

/* design/ncc_lane.sv */
// One feature lane: centroid feature memory, absolute difference and square.
module ncc_lane #(
  parameter int DEPTH  = ncc_pkg::MAX_CENTROIDS_DEF,
  parameter int ADDR_W = 6
) (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [ADDR_W-1:0]             wr_addr,
  input  logic [ncc_pkg::FEATURE_W-1:0] wr_data,
  input  logic [ADDR_W-1:0]             rd_addr,
  input  logic [ncc_pkg::FEATURE_W-1:0] query,
  output logic [ncc_pkg::SQ_W-1:0]      sq
);

  logic [ncc_pkg::FEATURE_W-1:0] mem [DEPTH];
  logic [ncc_pkg::FEATURE_W-1:0] rd_data_r;
  logic [ncc_pkg::FEATURE_W-1:0] diff;
  logic [ncc_pkg::SQ_W-1:0]      sq_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign diff = (query >= rd_data_r) ? (query - rd_data_r) : (rd_data_r - query);

  always_ff @(posedge clk) begin
    sq_r <= ncc_pkg::SQ_W'(diff) * ncc_pkg::SQ_W'(diff);
  end

  assign sq = sq_r;

endmodule

/* design/ncc_merge.sv */
// Merge stage: sums the lane squares and keeps the first strictly nearest entry.
module ncc_merge (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     clear,
  input  ncc_pkg::ncc_tag_t        tag_in,
  input  logic [ncc_pkg::SQ_W-1:0] sq_in [ncc_pkg::NUM_FEATURES],
  output ncc_pkg::ncc_best_t       best,
  output logic                     done
);

  logic [ncc_pkg::DIST_W-1:0] sum;
  logic [ncc_pkg::DIST_W-1:0] sum_r;
  ncc_pkg::ncc_tag_t          tag_r;
  ncc_pkg::ncc_best_t         best_r;
  logic                       done_r;

  always_comb begin
    sum = '0;
    for (int f = 0; f < ncc_pkg::NUM_FEATURES; f++) begin
      sum = sum + ncc_pkg::DIST_W'(sq_in[f]);
    end
  end

  always_ff @(posedge clk) begin
    sum_r <= sum;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r  <= '0;
      best_r <= '0;
      done_r <= 1'b0;
    end else begin
      tag_r  <= tag_in;
      done_r <= tag_r.valid && tag_r.last;
      if (clear) begin
        best_r <= '0;
      end else if (tag_r.valid && (!best_r.found || sum_r < best_r.sq_distance)) begin
        best_r.found       <= 1'b1;
        best_r.label       <= tag_r.label;
        best_r.index       <= tag_r.index;
        best_r.sq_distance <= sum_r;
      end
    end
  end

  assign best = best_r;
  assign done = done_r;

endmodule

/* design/nearest_centroid_classifier.sv */
// Nearest-centroid classifier: a load request writes one table entry; a classify request scans
// entries 0 to N-1, N being the configured count capped at MAX_CENTROIDS, one entry per cycle,
// and delivers its result on the output channel.
// The scan rate is set by the single read port of the per-feature table memories, all five
// feature lanes reading the same entry each cycle. No new request is taken during a scan; one
// result may wait in the output register while further requests are taken.
module nearest_centroid_classifier #(
  parameter int MAX_CENTROIDS = ncc_pkg::MAX_CENTROIDS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [ncc_pkg::COUNT_W-1:0] cfg_wdata,
  ncc_in_if.sink                      in_chan,
  ncc_out_if.source                   out_chan
);

  localparam int ADDR_W = (MAX_CENTROIDS > 1) ? $clog2(MAX_CENTROIDS) : 1;
  localparam int CNT_W  = $clog2(MAX_CENTROIDS + 1);

  logic [ncc_pkg::COUNT_W-1:0]   count_r;
  ncc_pkg::ncc_state_t           state_r, state_nxt;
  logic [ADDR_W-1:0]             addr_r, addr_nxt;
  logic [ADDR_W-1:0]             last_addr_r, last_addr_nxt;
  logic [CNT_W-1:0]              cnt_sat;
  logic [ncc_pkg::FEATURE_W-1:0] in_feat [ncc_pkg::NUM_FEATURES];
  logic [ncc_pkg::FEATURE_W-1:0] query_r [ncc_pkg::NUM_FEATURES];
  logic [ncc_pkg::SQ_W-1:0]      lane_sq [ncc_pkg::NUM_FEATURES];
  logic [ncc_pkg::LABEL_W-1:0]   label_mem [MAX_CENTROIDS];
  logic [ncc_pkg::LABEL_W-1:0]   label_rd_r;
  logic [ADDR_W-1:0]             wr_addr;
  logic                          in_ready;
  logic                          in_accept;
  logic                          load_we;
  logic                          issue_valid;
  logic                          issue_last;
  logic                          mrg_clear;
  logic                          mrg_done;
  logic                          out_load;
  ncc_pkg::ncc_tag_t             s1_r;
  ncc_pkg::ncc_tag_t             s2_r;
  ncc_pkg::ncc_best_t            mrg_best;
  ncc_pkg::ncc_best_t            out_r;
  logic                          out_valid_r;

  assign in_feat[0] = in_chan.feature_0;
  assign in_feat[1] = in_chan.feature_1;
  assign in_feat[2] = in_chan.feature_2;
  assign in_feat[3] = in_chan.feature_3;
  assign in_feat[4] = in_chan.feature_4;

  assign in_chan.ready = in_ready;
  assign in_accept     = in_chan.valid && in_ready;
  assign wr_addr       = ADDR_W'(in_chan.entry_index);
  assign load_we       = in_accept && (in_chan.cmd == ncc_pkg::CMD_LOAD)
                         && (int'(in_chan.entry_index) < MAX_CENTROIDS);
  assign cnt_sat       = (int'(count_r) > MAX_CENTROIDS) ? CNT_W'(MAX_CENTROIDS)
                                                         : CNT_W'(count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cfg_we) begin
      count_r <= cfg_wdata;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    addr_nxt      = addr_r;
    last_addr_nxt = last_addr_r;
    in_ready      = 1'b0;
    issue_valid   = 1'b0;
    issue_last    = 1'b0;
    mrg_clear     = 1'b0;
    out_load      = 1'b0;
    case (state_r)
      ncc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_accept && (in_chan.cmd == ncc_pkg::CMD_CLASSIFY)) begin
          mrg_clear = 1'b1;
          addr_nxt  = '0;
          if (cnt_sat == '0) begin
            state_nxt = ncc_pkg::ST_DONE;
          end else begin
            last_addr_nxt = ADDR_W'(cnt_sat - CNT_W'(1));
            state_nxt     = ncc_pkg::ST_SCAN;
          end
        end
      end
      ncc_pkg::ST_SCAN: begin
        issue_valid = 1'b1;
        issue_last  = (addr_r == last_addr_r);
        if (issue_last) begin
          state_nxt = ncc_pkg::ST_DRAIN;
        end else begin
          addr_nxt = addr_r + ADDR_W'(1);
        end
      end
      ncc_pkg::ST_DRAIN: begin
        if (mrg_done) begin
          state_nxt = ncc_pkg::ST_DONE;
        end
      end
      ncc_pkg::ST_DONE: begin
        if (!out_valid_r || out_chan.ready) begin
          out_load  = 1'b1;
          state_nxt = ncc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ncc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ncc_pkg::ST_IDLE;
      addr_r      <= '0;
      last_addr_r <= '0;
      s1_r        <= '0;
      s2_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      last_addr_r <= last_addr_nxt;
      s1_r.valid  <= issue_valid;
      s1_r.last   <= issue_last;
      s1_r.index  <= ncc_pkg::INDEX_W'(addr_r);
      s1_r.label  <= '0;
      s2_r.valid  <= s1_r.valid;
      s2_r.last   <= s1_r.last;
      s2_r.index  <= s1_r.index;
      s2_r.label  <= label_rd_r;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      query_r <= in_feat;
    end
    if (out_load) begin
      out_r <= mrg_best;
    end
  end

  always_ff @(posedge clk) begin
    if (load_we) begin
      label_mem[wr_addr] <= in_chan.entry_label;
    end
    label_rd_r <= label_mem[addr_r];
  end

  for (genvar f = 0; f < ncc_pkg::NUM_FEATURES; f++) begin : g_lane
    ncc_lane #(
      .DEPTH  (MAX_CENTROIDS),
      .ADDR_W (ADDR_W)
    ) u_lane (
      .clk     (clk),
      .wr_en   (load_we),
      .wr_addr (wr_addr),
      .wr_data (in_feat[f]),
      .rd_addr (addr_r),
      .query   (query_r[f]),
      .sq      (lane_sq[f])
    );
  end

  ncc_merge u_merge (
    .clk    (clk),
    .rst_n  (rst_n),
    .clear  (mrg_clear),
    .tag_in (s2_r),
    .sq_in  (lane_sq),
    .best   (mrg_best),
    .done   (mrg_done)
  );

  assign out_chan.valid            = out_valid_r;
  assign out_chan.found            = out_r.found;
  assign out_chan.best_label       = out_r.label;
  assign out_chan.best_index       = out_r.index;
  assign out_chan.best_sq_distance = out_r.sq_distance;

  a_scan_addr: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ncc_pkg::ST_SCAN |-> addr_r <= last_addr_r)
    else $error("scan address beyond last entry");

  a_done_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    mrg_done |-> state_r == ncc_pkg::ST_DRAIN)
    else $error("merge finished outside drain");

  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_r.found |->
      out_r.sq_distance == '0 && out_r.index == '0 && out_r.label == '0)
    else $error("empty result carries nonzero fields");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ncc_pkg::ST_DONE))
    else $error("result raised outside done state");

  a_issue_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    s1_r.valid |-> $past(state_r == ncc_pkg::ST_SCAN))
    else $error("table read issued outside scan");

endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench for the nearest-centroid classifier: directed table, then random traffic.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH = ncc_pkg::MAX_CENTROIDS_DEF;
  localparam int SETTLE      = 80;
  localparam int IDLE_LIMIT  = 3000;
  localparam int LONG_HOLD   = 400;
  localparam int NUM_PHASES  = 12;
  localparam int PHASE_ITEMS = 62;
  localparam logic [ncc_pkg::DIST_W-1:0] FULL_SCALE_SQ = 35'd21474181125;

  typedef logic [ncc_pkg::NUM_FEATURES-1:0][ncc_pkg::FEATURE_W-1:0] feat_vec_t;

  typedef struct packed {
    ncc_pkg::ncc_cmd_t           cmd;
    logic [ncc_pkg::INDEX_W-1:0] index;
    logic [ncc_pkg::LABEL_W-1:0] label;
    feat_vec_t                   feat;
  } ncc_req_t;

  typedef struct packed {
    logic                        set_count;
    logic [ncc_pkg::COUNT_W-1:0] count;
    ncc_req_t                    req;
    logic                        typed;
    ncc_pkg::ncc_best_t          want;
  } dir_row_t;

  localparam feat_vec_t V_ZERO = '0;
  localparam feat_vec_t V_ONES = '1;
  localparam feat_vec_t V_MIX  = {16'h7FFF, 16'h1234, 16'hFFFE, 16'h0001, 16'h8000};
  localparam feat_vec_t V_MID  = {5{16'h4000}};
  localparam feat_vec_t V_HALF = {16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF};
  localparam ncc_pkg::ncc_best_t NONE = '0;

  logic                        clk = 1'b0;
  logic                        rst_n;
  logic                        cfg_we;
  logic [ncc_pkg::COUNT_W-1:0] cfg_wdata;

  ncc_in_if  in_if();
  ncc_out_if out_if();

  nearest_centroid_classifier i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  always #1 clk = ~clk;

  feat_vec_t                   stored_vecs   [TABLE_DEPTH];
  logic [ncc_pkg::LABEL_W-1:0] stored_labels [TABLE_DEPTH];
  logic [ncc_pkg::COUNT_W-1:0] scan_count;
  ncc_pkg::ncc_best_t          predicted_matches [$];
  dir_row_t                    dir_rows [$];
  int                          mismatches = 0;
  bit                          hold_results = 1'b0;

  function automatic logic [ncc_pkg::DIST_W-1:0] sq_dist(feat_vec_t a, feat_vec_t b);
    logic [ncc_pkg::DIST_W-1:0]    acc;
    logic [ncc_pkg::DIST_W-1:0]    d;
    logic [ncc_pkg::FEATURE_W-1:0] diff;
    acc = '0;
    for (int f = 0; f < ncc_pkg::NUM_FEATURES; f++) begin
      diff = (a[f] >= b[f]) ? a[f] - b[f] : b[f] - a[f];
      d    = ncc_pkg::DIST_W'(diff);
      acc += d * d;
    end
    return acc;
  endfunction

  function automatic ncc_pkg::ncc_best_t nearest_match(feat_vec_t q);
    ncc_pkg::ncc_best_t         best;
    logic [ncc_pkg::DIST_W-1:0] d;
    int                         n;
    best = '0;
    n = (int'(scan_count) > TABLE_DEPTH) ? TABLE_DEPTH : int'(scan_count);
    for (int i = 0; i < n; i++) begin
      d = sq_dist(q, stored_vecs[i]);
      if (!best.found || d < best.sq_distance) begin
        best.found       = 1'b1;
        best.sq_distance = d;
        best.index       = ncc_pkg::INDEX_W'(i);
        best.label       = stored_labels[i];
      end
    end
    return best;
  endfunction

  function automatic ncc_req_t load_req(int idx, int label, feat_vec_t v);
    ncc_req_t r;
    r.cmd   = ncc_pkg::CMD_LOAD;
    r.index = ncc_pkg::INDEX_W'(idx);
    r.label = ncc_pkg::LABEL_W'(label);
    r.feat  = v;
    return r;
  endfunction

  function automatic ncc_req_t classify_req(feat_vec_t v);
    ncc_req_t r;
    r       = '0;
    r.cmd   = ncc_pkg::CMD_CLASSIFY;
    r.index = ncc_pkg::INDEX_W'($urandom);
    r.label = ncc_pkg::LABEL_W'($urandom);
    r.feat  = v;
    return r;
  endfunction

  function automatic ncc_pkg::ncc_best_t match(bit found, int label, int idx,
                                               logic [ncc_pkg::DIST_W-1:0] sq_d);
    ncc_pkg::ncc_best_t b;
    b.found       = found;
    b.label       = ncc_pkg::LABEL_W'(label);
    b.index       = ncc_pkg::INDEX_W'(idx);
    b.sq_distance = sq_d;
    return b;
  endfunction

  function automatic dir_row_t row(bit set, int cnt, ncc_req_t r, bit typed,
                                   ncc_pkg::ncc_best_t w);
    dir_row_t d;
    d.set_count = set;
    d.count     = ncc_pkg::COUNT_W'(cnt);
    d.req       = r;
    d.typed     = typed;
    d.want      = w;
    return d;
  endfunction

  function automatic void add_row(dir_row_t d);
    dir_rows.insert(dir_rows.size(), d);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int pick_run();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(1, 8);
    return $urandom_range(30, 150);
  endfunction

  function automatic feat_vec_t rand_vec();
    feat_vec_t v;
    for (int f = 0; f < ncc_pkg::NUM_FEATURES; f++) begin
      case ($urandom_range(0, 7))
        0: v[f] = 16'h0000;
        1: v[f] = 16'hFFFF;
        2: v[f] = ($urandom_range(0, 1) != 0) ? 16'h8000 : 16'h0001;
        default: v[f] = ncc_pkg::FEATURE_W'($urandom);
      endcase
    end
    return v;
  endfunction

  function automatic ncc_req_t rand_req();
    feat_vec_t v;
    if ($urandom_range(0, 9) < 3) begin
      v = ($urandom_range(0, 4) == 0) ? stored_vecs[$urandom_range(0, TABLE_DEPTH - 1)]
                                      : rand_vec();
      return load_req($urandom_range(0, TABLE_DEPTH - 1), $urandom, v);
    end
    case ($urandom_range(0, 2))
      0: v = rand_vec();
      1: v = stored_vecs[$urandom_range(0, TABLE_DEPTH - 1)];
      default: begin
        v = stored_vecs[$urandom_range(0, TABLE_DEPTH - 1)];
        v[$urandom_range(0, ncc_pkg::NUM_FEATURES - 1)] ^= 16'($urandom_range(1, 15));
      end
    endcase
    return classify_req(v);
  endfunction

  task automatic push_request(ncc_req_t r, bit typed, ncc_pkg::ncc_best_t want);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.cmd         <= r.cmd;
    in_if.entry_index <= r.index;
    in_if.entry_label <= r.label;
    in_if.feature_0   <= r.feat[0];
    in_if.feature_1   <= r.feat[1];
    in_if.feature_2   <= r.feat[2];
    in_if.feature_3   <= r.feat[3];
    in_if.feature_4   <= r.feat[4];
    do @(posedge clk); while (in_if.ready !== 1'b1);
    if (r.cmd == ncc_pkg::CMD_LOAD) begin
      stored_vecs[r.index]   = r.feat;
      stored_labels[r.index] = r.label;
    end else begin
      predicted_matches.insert(predicted_matches.size(),
                               typed ? want : nearest_match(r.feat));
    end
  endtask

  task automatic set_count(logic [ncc_pkg::COUNT_W-1:0] v);
    in_if.valid <= 1'b0;
    while (predicted_matches.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we     <= 1'b0;
    scan_count = v;
  endtask

  task automatic check_result();
    ncc_pkg::ncc_best_t got;
    ncc_pkg::ncc_best_t want;
    got.found       = out_if.found;
    got.label       = out_if.best_label;
    got.index       = out_if.best_index;
    got.sq_distance = out_if.best_sq_distance;
    if (predicted_matches.size() == 0) begin
      if (mismatches < 10)
        $display("%0t: result with none pending: found=%0d label=%0d index=%0d dist=%0d",
                 $realtime, got.found, got.label, got.index, got.sq_distance);
      mismatches++;
    end else begin
      want = predicted_matches.pop_front();
      if (got.found !== want.found || got.label !== want.label ||
          got.index !== want.index || got.sq_distance !== want.sq_distance) begin
        if (mismatches < 10)
          $display("%0t: mismatch: expected found=%0d label=%0d index=%0d dist=%0d, %s",
                   $realtime, want.found, want.label, want.index, want.sq_distance,
                   $sformatf("actual found=%0d label=%0d index=%0d dist=%0d",
                             got.found, got.label, got.index, got.sq_distance));
        mismatches++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) check_result();
  end

  initial begin : result_ready_drive
    int n;
    out_if.ready = 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (hold_results) begin
        hold_results = 1'b0;
        out_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        out_if.ready <= 1'b1;
        repeat (pick_run()) @(posedge clk);
        n = pick_gap();
        if (n > 0) begin
          out_if.ready <= 1'b0;
          repeat (n) @(posedge clk);
        end
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (rst_n !== 1'b1) @(posedge clk);
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
          (out_if.valid === 1'b1 && out_if.ready === 1'b1))
        idle = 0;
      else
        idle++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    logic [ncc_pkg::COUNT_W-1:0] settings [5];
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    in_if.valid       = 1'b0;
    in_if.cmd         = ncc_pkg::CMD_LOAD;
    in_if.entry_index = '0;
    in_if.entry_label = '0;
    in_if.feature_0   = '0;
    in_if.feature_1   = '0;
    in_if.feature_2   = '0;
    in_if.feature_3   = '0;
    in_if.feature_4   = '0;
    scan_count        = '0;
    settings          = '{7'd127, 7'd64, 7'd0, 7'd1, 7'd65};

    add_row(row(0, 0, classify_req(V_ONES), 1, match(0, 0, 0, 0)));
    add_row(row(0, 0, load_req(0, 5, V_ZERO), 0, NONE));
    add_row(row(0, 0, load_req(63, 15, V_ONES), 0, NONE));
    add_row(row(1, 1, classify_req(V_ONES), 1, match(1, 5, 0, FULL_SCALE_SQ)));
    add_row(row(0, 0, classify_req(V_ZERO), 1, match(1, 5, 0, 0)));
    add_row(row(0, 0, load_req(1, 15, V_ONES), 0, NONE));
    add_row(row(1, 2, classify_req(V_ONES), 1, match(1, 15, 1, 0)));
    add_row(row(0, 0, classify_req(V_ZERO), 1, match(1, 5, 0, 0)));
    add_row(row(0, 0, load_req(2, 9, V_ONES), 0, NONE));
    add_row(row(1, 3, classify_req(V_ONES), 1, match(1, 15, 1, 0)));
    add_row(row(0, 0, load_req(3, 0, V_MIX), 0, NONE));
    add_row(row(1, 4, classify_req(V_MIX), 1, match(1, 0, 3, 0)));
    add_row(row(0, 0, classify_req(V_MID), 0, NONE));
    add_row(row(0, 0, classify_req(V_HALF), 0, NONE));
    add_row(row(0, 0, load_req(2, 10, V_HALF), 0, NONE));
    add_row(row(0, 0, classify_req(V_HALF), 0, NONE));
    add_row(row(1, 0, classify_req(V_MIX), 1, match(0, 0, 0, 0)));
    add_row(row(1, 4, classify_req(V_MID), 0, NONE));
    add_row(row(0, 0, load_req(0, 3, V_MID), 0, NONE));
    add_row(row(0, 0, classify_req(V_MID), 0, NONE));
    add_row(row(0, 0, classify_req(V_ONES), 0, NONE));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].set_count) set_count(dir_rows[i].count);
      push_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);
    end

    for (int i = 0; i < TABLE_DEPTH; i++)
      push_request(load_req(i, $urandom, rand_vec()), 0, NONE);

    for (int p = 0; p < NUM_PHASES; p++) begin
      set_count((p < 5) ? settings[p] : ncc_pkg::COUNT_W'($urandom_range(0, 127)));
      if (p == 1) hold_results = 1'b1;
      repeat (PHASE_ITEMS) push_request(rand_req(), 0, NONE);
    end

    in_if.valid <= 1'b0;
    while (predicted_matches.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

/* nearest_centroid_classifier.f */
design/ncc_pkg.sv
design/ncc_chan_if.sv
design/ncc_lane.sv
design/ncc_merge.sv
design/nearest_centroid_classifier.sv
tb/sv/tb_top.sv
